// ----- rtl/magic_length_frame_command_parser_unit_defines.svh -----
// Assertion macros for the frame command parser checker.
// Needs nothing else; taken in by the checker file.
`ifndef MAGIC_LENGTH_FRAME_COMMAND_PARSER_UNIT_DEFINES_SVH
`define MAGIC_LENGTH_FRAME_COMMAND_PARSER_UNIT_DEFINES_SVH

// Clocked property, switched off while reset is low.
`define MLFCP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Signal stays unchanged in the cycle after a condition.
`define MLFCP_ASSERT_STABLE(lbl, clk, rstn, cond, sig, msg) \
  `MLFCP_ASSERT(lbl, clk, rstn, (cond) |=> $stable(sig), msg)

`endif

// ----- rtl/mlfcp_pkg.sv -----
// Shared types and constants of the frame command parser.
// Used by the front, the queue, the back end, the top level and the checker.
package mlfcp_pkg;

  localparam int RxBufferBytesDef = 4096;
  localparam int CodeBytesDef     = 2048;
  localparam int PinCountDef      = 11;

  // Offset and length width of a queue word; covers the largest buffer.
  localparam int LenW       = 16;
  localparam int QueueDepth = 2;
  localparam int QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW      = $clog2(QueueDepth + 1);

  localparam logic [7:0] MagicByte0 = 8'h50;
  localparam logic [7:0] MagicByte1 = 8'h4F;
  localparam logic [7:0] MagicByte2 = 8'h4B;
  localparam logic [7:0] MagicByte3 = 8'h45;

  // Command words, first payload byte in the low bits.
  localparam logic [31:0] CmdWordPing = 32'h474E4950;
  localparam logic [31:0] CmdWordInfo = 32'h4F464E49;
  localparam logic [31:0] CmdWordExec = 32'h43455845;
  localparam logic [31:0] CmdWordGpio = 32'h4F495047;
  localparam logic [31:0] CmdWordGpos = 32'h534F5047;
  localparam logic [31:0] CmdWordTemp = 32'h504D4554;

  localparam logic [7:0] RetOpcode  = 8'h80;
  localparam logic [7:0] RetPrefixA = 8'h67;
  localparam logic [7:0] RetPrefixB = 8'h82;

  localparam int TempBase  = 250;
  localparam int TempSteps = 30;

  typedef enum logic [2:0] {
    CMD_SHORT, CMD_PING, CMD_INFO, CMD_EXEC,
    CMD_GPIO_READ, CMD_GPIO_SET, CMD_TEMP, CMD_UNKNOWN
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK, ST_EXEC_SIZE, ST_EXEC_NO_RET, ST_SET_ARGS, ST_BAD_PIN
  } status_e;

  // One queue word: a payload byte, or an empty frame closing on its own.
  typedef struct packed {
    logic            is_byte;
    logic            last;
    logic [7:0]      data;
    logic [LenW-1:0] offset;
    logic [LenW-1:0] length;
  } entry_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = MagicByte0;
      2'd1:    b = MagicByte1;
      2'd2:    b = MagicByte2;
      default: b = MagicByte3;
    endcase
    return b;
  endfunction

endpackage

// ----- rtl/mlfcp_front.sv -----
// Front end: magic hunt, length collection and payload byte tagging.
// Depends on mlfcp_pkg; pushes words into mlfcp_queue.
module mlfcp_front import mlfcp_pkg::*; #(
  parameter int RX_BUFFER_BYTES = RxBufferBytesDef
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  input  logic   [7:0] rx_byte_i,
  output logic   in_stall_o,
  input  logic   full_i,
  output logic   push_o,
  output entry_t entry_o
);

  localparam int MaxLen = RX_BUFFER_BYTES - 8;
  localparam int FLW    = $clog2(MaxLen + 1);

  typedef enum logic [1:0] {PH_HUNT, PH_LENGTH, PH_PAYLOAD} phase_e;

  phase_e         phase_q;
  logic [1:0]     fc_q;
  logic [31:0]    acc_q;
  logic [FLW-1:0] len_q, off_q;

  logic           accept;
  logic [31:0]    acc_full;
  logic [FLW-1:0] off_inc;
  logic           len_ok;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign acc_full   = {rx_byte_i, acc_q[23:0]};
  assign off_inc    = off_q + FLW'(1);
  assign len_ok     = acc_full <= 32'(MaxLen);

  always_comb begin
    push_o  = 1'b0;
    entry_o = '0;
    case (phase_q)
      PH_LENGTH: begin
        // empty payload closes the frame on the last length byte
        if (accept && fc_q == 2'd3 && len_ok && acc_full == 32'd0) begin
          push_o       = 1'b1;
          entry_o.last = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        push_o          = accept;
        entry_o.is_byte = 1'b1;
        entry_o.last    = (off_inc == len_q);
        entry_o.data    = rx_byte_i;
        entry_o.offset  = LenW'(off_q);
        entry_o.length  = LenW'(len_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      fc_q    <= 2'd0;
      acc_q   <= 32'd0;
      len_q   <= '0;
      off_q   <= '0;
    end else if (accept) begin
      case (phase_q)
        PH_HUNT: begin
          if (rx_byte_i == magic_byte(fc_q)) begin
            if (fc_q == 2'd3) begin
              phase_q <= PH_LENGTH;
              fc_q    <= 2'd0;
              acc_q   <= 32'd0;
            end else begin
              fc_q <= fc_q + 2'd1;
            end
          end else begin
            // resync: a breaking 'P' starts a new match
            fc_q <= (rx_byte_i == MagicByte0) ? 2'd1 : 2'd0;
          end
        end
        PH_LENGTH: begin
          acc_q <= acc_q | ({24'd0, rx_byte_i} << {fc_q, 3'b000});
          fc_q  <= fc_q + 2'd1;
          if (fc_q == 2'd3) begin
            if (!len_ok || acc_full == 32'd0) begin
              phase_q <= PH_HUNT;
            end else begin
              phase_q <= PH_PAYLOAD;
              len_q   <= acc_full[FLW-1:0];
              off_q   <= '0;
            end
          end
        end
        PH_PAYLOAD: begin
          off_q <= off_inc;
          if (off_inc == len_q) begin
            phase_q <= PH_HUNT;
            fc_q    <= 2'd0;
          end
        end
        default: phase_q <= PH_HUNT;
      endcase
    end
  end

endmodule

// ----- rtl/mlfcp_queue.sv -----
// Short word queue between the front end and the back end.
// Depends on mlfcp_pkg for the word type and depth.
module mlfcp_queue import mlfcp_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  output logic   full_o,
  input  logic   pop_i,
  output entry_t entry_o,
  output logic   empty_o
);

  entry_t           slot_q [QueueDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;

  assign full_o  = (cnt_q == QCntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign entry_o = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_q + QPtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

endmodule

// ----- rtl/mlfcp_back.sv -----
// Back end: command capture, return scan, verdicts, virtual pins and temperature.
// Depends on mlfcp_pkg; pops words from mlfcp_queue and owns the output register.
module mlfcp_back import mlfcp_pkg::*; #(
  parameter int CODE_BYTES = CodeBytesDef,
  parameter int PIN_COUNT  = PinCountDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  entry_t      head_i,
  input  logic        empty_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        byte_valid_o,
  output logic [7:0]  payload_byte_o,
  output logic [11:0] payload_offset_o,
  output logic        frame_end_o,
  output logic [11:0] payload_length_o,
  output logic [2:0]  command_o,
  output logic [2:0]  status_o,
  output logic        return_found_o,
  output logic [10:0] pin_levels_o,
  output logic [8:0]  temp_tenths_o
);

  logic [31:0]          cmdw_q, cmdw_n;
  logic [7:0]           prev_q, prev_n;
  logic                 ret_q, ret_n;
  logic [7:0]           pin_req_q, pin_req_n;
  logic                 lvl_q, lvl_n;
  logic [PIN_COUNT-1:0] pins_q, pins_n;
  logic [4:0]           tick_q, tick_n;

  cmd_e    cmd_n;
  status_e st_n;
  logic    rf_n;
  logic [8:0] temp_n;

  logic        out_valid_q;
  logic        bv_q, fe_q, rf_q;
  logic [7:0]  pb_q;
  logic [11:0] po_q, pl_q;
  cmd_e        cmd_q;
  status_e     st_q;
  logic [10:0] pl_lvl_q;
  logic [8:0]  temp_q;

  logic [LenW-1:0] off, len;
  logic [7:0]      b;

  assign pop_o = !empty_i && (!out_valid_q || !out_stall_i);
  assign off   = head_i.offset;
  assign len   = head_i.length;
  assign b     = head_i.data;

  always_comb begin
    cmdw_n    = cmdw_q;
    prev_n    = prev_q;
    ret_n     = ret_q;
    pin_req_n = pin_req_q;
    lvl_n     = lvl_q;
    pins_n    = pins_q;
    tick_n    = tick_q;
    cmd_n     = CMD_SHORT;
    st_n      = ST_OK;
    rf_n      = 1'b0;
    temp_n    = 9'd0;

    if (head_i.is_byte) begin
      if (off < LenW'(4)) begin
        cmdw_n[{off[1:0], 3'b000} +: 8] = b;
      end
      if (off == LenW'(0)) begin
        ret_n = 1'b0;
      end
      if (off == LenW'(4)) begin
        pin_req_n = b;
      end
      if (off == LenW'(5)) begin
        lvl_n = (b != 8'd0);
      end
      if (off >= LenW'(5) && b == RetOpcode &&
          (prev_q == RetPrefixA || prev_q == RetPrefixB)) begin
        ret_n = 1'b1;
      end
      prev_n = b;
    end

    if (head_i.last && len >= LenW'(4)) begin
      case (cmdw_n)
        CmdWordPing: cmd_n = CMD_PING;
        CmdWordInfo: cmd_n = CMD_INFO;
        CmdWordExec: begin
          cmd_n = CMD_EXEC;
          // code is the payload after the command word
          if (len == LenW'(4) || 32'(len) > 32'(CODE_BYTES + 4)) begin
            st_n = ST_EXEC_SIZE;
          end else if (!ret_n) begin
            st_n = ST_EXEC_NO_RET;
          end else begin
            rf_n = 1'b1;
          end
        end
        CmdWordGpio: cmd_n = CMD_GPIO_READ;
        CmdWordGpos: begin
          cmd_n = CMD_GPIO_SET;
          if (len < LenW'(6)) begin
            st_n = ST_SET_ARGS;
          end else if (32'(pin_req_n) >= 32'(PIN_COUNT)) begin
            st_n = ST_BAD_PIN;
          end else begin
            for (int i = 0; i < PIN_COUNT; i++) begin
              if (pin_req_n == 8'(i)) begin
                pins_n[i] = lvl_n;
              end
            end
          end
        end
        CmdWordTemp: begin
          cmd_n  = CMD_TEMP;
          tick_n = (tick_q == 5'(TempSteps - 1)) ? 5'd0 : tick_q + 5'd1;
          temp_n = 9'(TempBase) + {4'd0, tick_n};
        end
        default: cmd_n = CMD_UNKNOWN;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cmdw_q      <= 32'd0;
      prev_q      <= 8'd0;
      ret_q       <= 1'b0;
      pin_req_q   <= 8'd0;
      lvl_q       <= 1'b0;
      pins_q      <= '0;
      tick_q      <= 5'd0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
      cmdw_q      <= cmdw_n;
      prev_q      <= prev_n;
      ret_q       <= ret_n;
      pin_req_q   <= pin_req_n;
      lvl_q       <= lvl_n;
      pins_q      <= pins_n;
      tick_q      <= tick_n;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result word; hold while stalled
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      bv_q     <= head_i.is_byte;
      pb_q     <= head_i.is_byte ? b : 8'd0;
      po_q     <= head_i.is_byte ? 12'(off) : 12'd0;
      fe_q     <= head_i.last;
      pl_q     <= head_i.last ? 12'(len) : 12'd0;
      cmd_q    <= cmd_n;
      st_q     <= st_n;
      rf_q     <= rf_n;
      pl_lvl_q <= 11'(pins_n);
      temp_q   <= temp_n;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign byte_valid_o     = bv_q;
  assign payload_byte_o   = pb_q;
  assign payload_offset_o = po_q;
  assign frame_end_o      = fe_q;
  assign payload_length_o = pl_q;
  assign command_o        = cmd_q;
  assign status_o         = st_q;
  assign return_found_o   = rf_q;
  assign pin_levels_o     = pl_lvl_q;
  assign temp_tenths_o    = temp_q;

endmodule

// ----- rtl/magic_length_frame_command_parser_unit.sv -----
// Top level of the magic and length frame command parser.
// Depends on mlfcp_pkg, mlfcp_front, mlfcp_queue and mlfcp_back.
//
//  channel  direction  handshake               payload
//  in       sink       in_valid_i / in_stall_o   rx_byte_i
//  out      source     out_valid_o / out_stall_i byte_valid_o .. temp_tenths_o
//
// One byte accepted per cycle unless stalled; constant front-end work per byte.
// A payload byte or an empty frame shows its result after the queue slot
// (written at the accepting edge) and then the output register; header and
// hunt bytes give none.
// in_stall_o rises only when the two-word queue is full behind a stalled output.
// Reset (rst_ni low, asynchronous) empties the queue and output and clears
// the parse state, virtual pins and temperature tick.
module magic_length_frame_command_parser_unit import mlfcp_pkg::*; #(
  parameter int RX_BUFFER_BYTES = RxBufferBytesDef,
  parameter int CODE_BYTES      = CodeBytesDef,
  parameter int PIN_COUNT       = PinCountDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        byte_valid_o,
  output logic [7:0]  payload_byte_o,
  output logic [11:0] payload_offset_o,
  output logic        frame_end_o,
  output logic [11:0] payload_length_o,
  output logic [2:0]  command_o,
  output logic [2:0]  status_o,
  output logic        return_found_o,
  output logic [10:0] pin_levels_o,
  output logic [8:0]  temp_tenths_o
);

  logic   push, full, pop, empty;
  entry_t push_word, head_word;

  mlfcp_front #(
    .RX_BUFFER_BYTES(RX_BUFFER_BYTES)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .rx_byte_i (rx_byte_i),
    .in_stall_o(in_stall_o),
    .full_i    (full),
    .push_o    (push),
    .entry_o   (push_word)
  );

  mlfcp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(push_word),
    .full_o (full),
    .pop_i  (pop),
    .entry_o(head_word),
    .empty_o(empty)
  );

  mlfcp_back #(
    .CODE_BYTES(CODE_BYTES),
    .PIN_COUNT (PIN_COUNT)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head_word),
    .empty_i         (empty),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .byte_valid_o    (byte_valid_o),
    .payload_byte_o  (payload_byte_o),
    .payload_offset_o(payload_offset_o),
    .frame_end_o     (frame_end_o),
    .payload_length_o(payload_length_o),
    .command_o       (command_o),
    .status_o        (status_o),
    .return_found_o  (return_found_o),
    .pin_levels_o    (pin_levels_o),
    .temp_tenths_o   (temp_tenths_o)
  );

endmodule

// ----- rtl/mlfcp_checker.sv -----
// Port-level checker for the frame command parser, bound to the top level.
// Depends on mlfcp_pkg and the defines header.
`include "magic_length_frame_command_parser_unit_defines.svh"

module mlfcp_checker import mlfcp_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [7:0]  rx_byte_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        byte_valid_o,
  input logic [7:0]  payload_byte_o,
  input logic [11:0] payload_offset_o,
  input logic        frame_end_o,
  input logic [11:0] payload_length_o,
  input logic [2:0]  command_o,
  input logic [2:0]  status_o,
  input logic        return_found_o,
  input logic [10:0] pin_levels_o,
  input logic [8:0]  temp_tenths_o
);

  `MLFCP_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o, "result word dropped while stalled")
  `MLFCP_ASSERT_STABLE(a_out_byte_stable, clk_i, rst_ni, out_valid_o && out_stall_i, payload_byte_o, "payload byte changed while stalled")
  `MLFCP_ASSERT(a_empty_closes, clk_i, rst_ni, out_valid_o && !byte_valid_o |-> frame_end_o, "result word without byte or frame end")
  `MLFCP_ASSERT(a_verdict_at_end, clk_i, rst_ni, out_valid_o && !frame_end_o |-> command_o == CMD_SHORT && status_o == ST_OK && !return_found_o, "verdict outside frame end")
  `MLFCP_ASSERT(a_temp_only, clk_i, rst_ni, out_valid_o && command_o != CMD_TEMP |-> temp_tenths_o == 9'd0, "temperature reported for another command")

endmodule

bind magic_length_frame_command_parser_unit mlfcp_checker u_checker (.*);
